>>> hdl/msp_pkg.sv
`default_nettype none

package msp_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int NUM_STACKS = 4;

    localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         stack_number;
        logic signed [31:0] push_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } out_word_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_data_en;
        logic              wr_link_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [31:0]       wr_data;
        logic [PTR_W-1:0]  wr_link;
    } mem_req_t;

    typedef struct packed {
        logic [31:0]      data;
        logic [PTR_W-1:0] link;
    } mem_rsp_t;

endpackage

`default_nettype wire

>>> hdl/msp_pool_mem.sv
`default_nettype none

module msp_pool_mem (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire msp_pkg::mem_req_t req,
    output msp_pkg::mem_rsp_t      rsp
);
    import msp_pkg::*;

    logic [31:0]      data_mem [POOL_DEPTH];
    logic [PTR_W-1:0] link_mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] link_valid_reg;

    logic [31:0]       rd_data_reg;
    logic [PTR_W-1:0]  rd_link_reg;
    logic              rd_lvalid_reg;
    logic [ADDR_W-1:0] rd_addr_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_data_en) begin
            data_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.wr_link_en) begin
            link_mem[req.wr_addr] <= req.wr_link;
        end
        if (req.rd_en) begin
            rd_data_reg <= data_mem[req.rd_addr];
            rd_link_reg <= link_mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    // An entry whose link was never written still links to its successor,
    // which leaves the whole pool on the free list after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_valid_reg <= '0;
            rd_lvalid_reg  <= 1'b0;
        end else begin
            if (req.wr_link_en) begin
                link_valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_lvalid_reg <= link_valid_reg[req.rd_addr];
            end
        end
    end

    assign rsp.data = rd_data_reg;
    assign rsp.link = rd_lvalid_reg ? rd_link_reg
                                    : PTR_W'(rd_addr_reg) + PTR_W'(1);

endmodule

`default_nettype wire

>>> hdl/multi_stack_shared_pool_unit.sv
`default_nettype none

// The result of an accepted word is formed in the execute state from a registered read
// of the pool memory (data and link of the stack's head entry, or of the free entry for
// a push) that precedes the write back; a new word is taken only in the idle state.
// A finished result waits in an output register while the next word is accepted.
// Reset (aresetn, synchronous, active low): all stacks empty, every pool entry on the
// free list in order from entry zero; no clearing pass, the block is ready at once.
module multi_stack_shared_pool_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire msp_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output msp_pkg::out_word_t      m_data
);
    import msp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    in_word_t         item_reg;
    logic [PTR_W-1:0] free_head_reg, free_head_next;
    logic [PTR_W-1:0] stack_head_reg  [NUM_STACKS];
    logic [PTR_W-1:0] stack_head_next [NUM_STACKS];
    logic             m_valid_reg, m_valid_next;
    out_word_t        out_reg, out_next;

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    logic             accept;
    logic [STK_W-1:0] in_idx;
    logic [STK_W-1:0] cur_idx;
    logic             sn_ok;
    logic [PTR_W-1:0] cur_head;
    logic             head_ok;
    logic             free_ok;

    msp_pool_mem u_pool_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rsp     (mem_rsp)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign in_idx   = STK_W'(s_data.stack_number);
    assign cur_idx  = STK_W'(item_reg.stack_number);
    assign sn_ok    = (int'(item_reg.stack_number) < NUM_STACKS);
    assign cur_head = stack_head_reg[cur_idx];
    assign head_ok  = sn_ok && (cur_head < NULL_PTR);
    assign free_ok  = free_head_reg < NULL_PTR;

    always_comb begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        stack_head_next = stack_head_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        mem_req         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // Push needs the free entry's link, pop and peek the head entry.
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = (s_data.opcode == OP_PUSH)
                                      ? ADDR_W'(free_head_reg)
                                      : ADDR_W'(stack_head_reg[in_idx]);
                    state_next      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    out_next     = '{read_value: 32'sd0, status: STAT_OK};
                    case (item_reg.opcode) inside
                        OP_PUSH: begin
                            if (sn_ok && free_ok) begin
                                mem_req.wr_data_en       = 1'b1;
                                mem_req.wr_link_en       = 1'b1;
                                mem_req.wr_addr          = ADDR_W'(free_head_reg);
                                mem_req.wr_data          = item_reg.push_value;
                                mem_req.wr_link          = cur_head;
                                free_head_next           = mem_rsp.link;
                                stack_head_next[cur_idx] = free_head_reg;
                            end else begin
                                out_next.status = STAT_OVERFLOW;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (head_ok) begin
                                out_next.read_value = mem_rsp.data;
                                if (item_reg.opcode == OP_POP) begin
                                    mem_req.wr_link_en       = 1'b1;
                                    mem_req.wr_addr          = ADDR_W'(cur_head);
                                    mem_req.wr_link          = free_head_reg;
                                    free_head_next           = cur_head;
                                    stack_head_next[cur_idx] = mem_rsp.link;
                                end
                            end else begin
                                out_next.read_value = -32'sd1;
                                out_next.status     = STAT_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                stack_head_reg[i] <= NULL_PTR;
            end
        end else begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            m_valid_reg    <= m_valid_next;
            stack_head_reg <= stack_head_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_EXEC)
        else $error("accepted word did not move to execute");

    a_write_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_req.wr_link_en || mem_req.wr_data_en) |-> state_reg == S_EXEC)
        else $error("pool write outside execute");

    a_free_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg <= NULL_PTR)
        else $error("free list head out of range");

    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status == STAT_EMPTY) |-> out_reg.read_value == -32'sd1)
        else $error("empty status without all-ones word");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
    import msp_pkg::*;

    // Opcode three is not decoded by the block; it still answers with one word.
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT = 29;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    multi_stack_shared_pool_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the pool, the free list and the stack heads.
    logic [31:0]      pool_data [POOL_DEPTH];
    logic [PTR_W-1:0] pool_link [POOL_DEPTH];
    logic [PTR_W-1:0] stack_top [NUM_STACKS];
    logic [PTR_W-1:0] free_top;

    in_word_t  ops_pending [$];
    out_word_t results_due [$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        words_sent = 0;
    int        results_seen = 0;
    bit        in_taken = 1'b0;

    function automatic out_word_t pool_apply(in_word_t w);
        out_word_t         r;
        logic [ADDR_W-1:0] idx;
        bit                sn_ok;
        r.read_value = '0;
        r.status = STAT_OK;
        sn_ok = int'(w.stack_number) < NUM_STACKS;
        case (w.opcode) inside
            OP_PUSH: begin
                if (!sn_ok || free_top >= POOL_DEPTH) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    idx = ADDR_W'(free_top);
                    free_top = pool_link[idx];
                    pool_data[idx] = w.push_value;
                    pool_link[idx] = stack_top[w.stack_number];
                    stack_top[w.stack_number] = PTR_W'(idx);
                end
            end
            OP_POP, OP_PEEK: begin
                if (!sn_ok || stack_top[w.stack_number] >= POOL_DEPTH) begin
                    r.read_value = -32'sd1;
                    r.status = STAT_EMPTY;
                end else begin
                    idx = ADDR_W'(stack_top[w.stack_number]);
                    r.read_value = pool_data[idx];
                    if (w.opcode == OP_POP) begin
                        stack_top[w.stack_number] = pool_link[idx];
                        pool_link[idx] = free_top;
                        free_top = PTR_W'(idx);
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch on result word %0d: %s is %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    function automatic in_word_t op_word(logic [1:0] op, int sn, logic [31:0] val);
        in_word_t w;
        w.opcode = op;
        w.stack_number = sn[1:0];
        w.push_value = val;
        return w;
    endfunction

    // Random traffic in bursts; the push share swings so the pool fills and drains.
    task automatic add_random(int count);
        int push_pct;
        int r;
        in_word_t w;
        push_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            r = $urandom_range(99);
            if (r < 3) begin
                w = op_word(OP_NOP, $urandom_range(3), $urandom());
            end else if ($urandom_range(99) < push_pct) begin
                w = op_word(OP_PUSH, $urandom_range(3), $urandom());
            end else if ($urandom_range(2) == 0) begin
                w = op_word(OP_PEEK, $urandom_range(3), $urandom());
            end else begin
                w = op_word(OP_POP, $urandom_range(3), $urandom());
            end
            ops_pending.push_back(w);
        end
    endtask

    task automatic wait_drained();
        while (ops_pending.size() != 0 || s_valid || results_due.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: a word stays on the bus until taken, then the next one may follow.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // Hold the current word.
        end else if (ops_pending.size() != 0 &&
                     ((words_sent >= 200 && words_sent < 320) ||
                      $urandom_range(99) >= IDLE_PCT)) begin
            s_data <= ops_pending.pop_front();
            s_valid <= 1'b1;
            words_sent++;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        m_ready <= (results_seen >= 200 && results_seen < 320) ||
                   ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on input acceptance, check on output acceptance.
    always @(posedge aclk) begin
        out_word_t want;
        cycle_count++;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken)
            results_due.push_back(pool_apply(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                flag_mismatch("count of words due", 0, 1);
            end else begin
                want = results_due.pop_front();
                if (m_data.read_value !== want.read_value)
                    flag_mismatch("read_value", m_data.read_value, want.read_value);
                if (m_data.status !== want.status)
                    flag_mismatch("status", m_data.status, want.status);
            end
            results_seen++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", results_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_data[i] = '0;
            pool_link[i] = PTR_W'(i + 1);
        end
        for (int i = 0; i < NUM_STACKS; i++)
            stack_top[i] = NULL_PTR;
        free_top = '0;

        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // Empty stacks, the unused opcode, word extremes, then fill the pool past full.
        ops_pending.push_back(op_word(OP_POP, 0, 32'h1234_5678));
        ops_pending.push_back(op_word(OP_PEEK, 3, 32'h0));
        ops_pending.push_back(op_word(OP_NOP, 2, 32'hDEAD_BEEF));
        ops_pending.push_back(op_word(OP_PUSH, 0, 32'h7FFF_FFFF));
        ops_pending.push_back(op_word(OP_PUSH, 1, 32'h8000_0000));
        ops_pending.push_back(op_word(OP_PEEK, 1, 32'hFFFF_FFFF));
        ops_pending.push_back(op_word(OP_POP, 0, 32'h0));
        ops_pending.push_back(op_word(OP_POP, 0, 32'h0));
        ops_pending.push_back(op_word(OP_POP, 1, 32'h0));
        for (int i = 0; i < POOL_DEPTH; i++)
            ops_pending.push_back(op_word(OP_PUSH, i % NUM_STACKS,
                                          i == 0 ? 32'hFFFF_FFFF :
                                          i == 1 ? 32'h0 : $urandom()));
        ops_pending.push_back(op_word(OP_PUSH, 2, 32'h5555_AAAA));
        wait_drained();

        add_random(225);
        wait_drained();
        add_random(225);
        wait_drained();

        repeat (10) @(negedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
